// File: hw/rtl/circular_double_ended_queue_assert.svh
// Assertion macros shared by the deque checker.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef CIRCULAR_DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define CIRCULAR_DOUBLE_ENDED_QUEUE_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define CDQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("%m: check failed");

// Next-cycle implication, disabled during reset
`define CDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("%m: check failed");

`endif

// File: hw/rtl/cdq_pkg.sv
// Shared types and constants of the circular double-ended queue.
// Used by the channel interfaces, the top level and the checker.
`timescale 1ns / 1ps

package cdq_pkg;

	localparam int DEPTH   = 16;
	localparam int VALUE_W = 32;
	localparam int IDX_W   = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int KIND_W  = 3;
	localparam int STAT_W  = 2;
	localparam int CAP_W   = 5;

	// Operation codes
	localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
	localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_QUERY      = 3'd4;

	// Status codes
	localparam logic [STAT_W-1:0] STAT_DONE      = 2'd0;
	localparam logic [STAT_W-1:0] STAT_REJ_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_REJ_EMPTY = 2'd2;

	// Value reported at both ends of an empty deque
	localparam logic signed [VALUE_W-1:0] EMPTY_MARK = '1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_RESP
	} cdq_state_t;

endpackage

// File: hw/rtl/cdq_cmd_if.sv
// Command channel of the deque: operation kind and push value.
// Depends on cdq_pkg for field widths.
`timescale 1ns / 1ps

interface cdq_cmd_if import cdq_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [KIND_W-1:0]         kind;
	logic signed [VALUE_W-1:0] push_value;

	modport source (output valid, output kind, output push_value, input ready);
	modport sink   (input valid, input kind, input push_value, output ready);
endinterface

// File: hw/rtl/cdq_rsp_if.sv
// Response channel of the deque: end values, count, flags and status.
// Depends on cdq_pkg for field widths.
`timescale 1ns / 1ps

interface cdq_rsp_if import cdq_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] front_value;
	logic signed [VALUE_W-1:0] rear_value;
	logic [CNT_W-1:0]          entry_count;
	logic                      is_empty;
	logic                      is_full;
	logic [STAT_W-1:0]         status;

	modport source (output valid, output front_value, output rear_value,
		output entry_count, output is_empty, output is_full, output status, input ready);
	modport sink   (input valid, input front_value, input rear_value,
		input entry_count, input is_empty, input is_full, input status, output ready);
endinterface

// File: hw/rtl/circular_double_ended_queue.sv
// Circular double-ended queue over a synchronous slot memory; uses cdq_pkg and both channels.
// Each command passes through the index update, the memory read and the response register.
// A new command is taken only when idle, once the last result is in the response register.
// A waiting result sits in the response register and does not block the next update.
// Reset (arst_n low): empty deque, indices 0, capacity 16, no result pending.
// The slot memory is not cleared; while the deque is empty, its ends report the empty mark.
`timescale 1ns / 1ps

module circular_double_ended_queue import cdq_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	cdq_cmd_if.sink          cmd,
	cdq_rsp_if.source        rsp,
	input  logic             cfg_wr_en,
	input  logic [CAP_W-1:0] cfg_wr_data
);

	logic [VALUE_W-1:0] slot_mem [DEPTH];

	cdq_state_t         state_q, state_d;
	logic [CAP_W-1:0]   cap_reg_q;
	logic [IDX_W-1:0]   front_q, rear_q;
	logic [CNT_W-1:0]   count_q;
	logic [STAT_W-1:0]  status_q;
	logic [VALUE_W-1:0] front_rd_s2, rear_rd_s2;
	logic               rsp_valid_q;
	logic signed [VALUE_W-1:0] rsp_front_q, rsp_rear_q;
	logic [CNT_W-1:0]   rsp_count_q;
	logic               rsp_full_q;
	logic [STAT_W-1:0]  rsp_status_q;

	logic               cmd_xfer;
	logic               rsp_load;
	logic [CNT_W-1:0]   cap_eff;
	logic               is_full_now;
	logic [IDX_W-1:0]   front_up, front_down, rear_up, rear_down;
	logic [IDX_W-1:0]   front_d, rear_d;
	logic [CNT_W-1:0]   count_d;
	logic [STAT_W-1:0]  status_d;
	logic               wr_en;
	logic [IDX_W-1:0]   wr_addr;

	// Clamp the capacity register to 1..DEPTH
	always_comb begin
		if (cap_reg_q == '0) begin
			cap_eff = CNT_W'(1);
		end else if (CNT_W'(cap_reg_q) > CNT_W'(DEPTH)) begin
			cap_eff = CNT_W'(DEPTH);
		end else begin
			cap_eff = CNT_W'(cap_reg_q);
		end
	end

	assign is_full_now = count_q >= cap_eff;

	// Circular index steps, wrapping at the effective capacity
	always_comb begin
		front_up = ((CNT_W'(front_q) + CNT_W'(1)) >= cap_eff) ? '0 : front_q + IDX_W'(1);
		rear_up  = ((CNT_W'(rear_q) + CNT_W'(1)) >= cap_eff) ? '0 : rear_q + IDX_W'(1);
		front_down = (front_q == '0 || CNT_W'(front_q) >= cap_eff)
			? IDX_W'(cap_eff - CNT_W'(1)) : front_q - IDX_W'(1);
		rear_down  = (rear_q == '0 || CNT_W'(rear_q) >= cap_eff)
			? IDX_W'(cap_eff - CNT_W'(1)) : rear_q - IDX_W'(1);
	end

	// Decode the operation into new indices, count, status and a slot write
	always_comb begin
		front_d  = front_q;
		rear_d   = rear_q;
		count_d  = count_q;
		status_d = STAT_DONE;
		wr_en    = 1'b0;
		wr_addr  = '0;
		unique case (cmd.kind) inside
			KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
				if (is_full_now) begin
					status_d = STAT_REJ_FULL;
				end else begin
					wr_en   = 1'b1;
					count_d = count_q + CNT_W'(1);
					if (count_q == '0) begin
						front_d = '0;
						rear_d  = '0;
						wr_addr = '0;
					end else if (cmd.kind == KIND_PUSH_FRONT) begin
						front_d = front_down;
						wr_addr = front_down;
					end else begin
						rear_d  = rear_up;
						wr_addr = rear_up;
					end
				end
			end
			KIND_POP_FRONT, KIND_POP_BACK: begin
				if (count_q == '0) begin
					status_d = STAT_REJ_EMPTY;
				end else begin
					count_d = count_q - CNT_W'(1);
					if (count_q == CNT_W'(1)) begin
						front_d = '0;
						rear_d  = '0;
					end else if (cmd.kind == KIND_POP_FRONT) begin
						front_d = front_up;
					end else begin
						rear_d = rear_down;
					end
				end
			end
			default: begin
				// Query and unused codes leave the state as it is
				status_d = STAT_DONE;
			end
		endcase
	end

	// Sequencer: update, read both ends, hand the result to the response register
	always_comb begin
		state_d   = state_q;
		cmd.ready = 1'b0;
		rsp_load  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.ready = 1'b1;
				if (cmd.valid) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				state_d = ST_RESP;
			end
			ST_RESP: begin
				if (!rsp_valid_q || rsp.ready) begin
					rsp_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign cmd_xfer = cmd.valid && cmd.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_reg_q <= CAP_W'(DEPTH);
		end else if (cfg_wr_en) begin
			cap_reg_q <= cfg_wr_data;
		end
	end

	// Advance indices and count on each command transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q  <= '0;
			rear_q   <= '0;
			count_q  <= '0;
			status_q <= STAT_DONE;
		end else if (cmd_xfer) begin
			front_q  <= front_d;
			rear_q   <= rear_d;
			count_q  <= count_d;
			status_q <= status_d;
		end
	end

	// Slot memory: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (cmd_xfer && wr_en) begin
			slot_mem[wr_addr] <= cmd.push_value;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			front_rd_s2 <= slot_mem[front_q];
			rear_rd_s2  <= slot_mem[rear_q];
		end
	end

	// Response register: hold until the sink takes the transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_front_q  <= (count_q == '0) ? EMPTY_MARK : front_rd_s2;
			rsp_rear_q   <= (count_q == '0) ? EMPTY_MARK : rear_rd_s2;
			rsp_count_q  <= count_q;
			rsp_full_q   <= is_full_now;
			rsp_status_q <= status_q;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.front_value = rsp_front_q;
	assign rsp.rear_value  = rsp_rear_q;
	assign rsp.entry_count = rsp_count_q;
	assign rsp.is_empty    = (rsp_count_q == '0);
	assign rsp.is_full     = rsp_full_q;
	assign rsp.status      = rsp_status_q;

endmodule

// File: hw/rtl/cdq_checker.sv
// Port-level checks of the circular double-ended queue, bound to the top level.
// Depends on cdq_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "circular_double_ended_queue_assert.svh"

module cdq_checker import cdq_pkg::*; (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      rsp_valid,
	input logic                      rsp_ready,
	input logic signed [VALUE_W-1:0] front_value,
	input logic signed [VALUE_W-1:0] rear_value,
	input logic [CNT_W-1:0]          entry_count,
	input logic                      is_empty,
	input logic                      is_full,
	input logic [STAT_W-1:0]         status
);

	// A stalled result stays offered
	`CDQ_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid)

	// An empty deque reports the empty mark at both ends
	`CDQ_ASSERT_NOW(a_empty_mark, clk, arst_n, rsp_valid && is_empty,
		entry_count == '0 && front_value == EMPTY_MARK && rear_value == EMPTY_MARK)

	// A rejected push leaves a full deque, a rejected pop an empty one
	`CDQ_ASSERT_NOW(a_reject_flags, clk, arst_n,
		rsp_valid && (status == STAT_REJ_FULL || status == STAT_REJ_EMPTY),
		(status == STAT_REJ_FULL) ? is_full : is_empty)

	// The count never exceeds the store depth and the status is a known code
	`CDQ_ASSERT_NOW(a_count_range, clk, arst_n, rsp_valid,
		entry_count <= CNT_W'(DEPTH) && status <= STAT_REJ_EMPTY)

endmodule

bind circular_double_ended_queue cdq_checker u_cdq_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.front_value (rsp.front_value),
	.rear_value  (rsp.rear_value),
	.entry_count (rsp.entry_count),
	.is_empty    (rsp.is_empty),
	.is_full     (rsp.is_full),
	.status      (rsp.status)
);
